/* rtl/core/obd2_pid_poll_and_decode_assert.svh */
// ----------------------------------------------------------------------------
// OBD-II poller assertion macros
// Shared concurrent assertion forms used by the poller RTL.
// ----------------------------------------------------------------------------
`ifndef OBD2_PID_POLL_AND_DECODE_ASSERT_SVH
`define OBD2_PID_POLL_AND_DECODE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define OBD2PP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define OBD2PP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/obd2pp_pkg.sv */
// ----------------------------------------------------------------------------
// OBD-II poller package
// Slot table, result codes, widths and decode constants.
// ----------------------------------------------------------------------------
package obd2pp_pkg;

  localparam int SLOT_COUNT = 7;
  localparam int SLOT_W     = 3;
  localparam int VALUE_W    = 25;
  localparam int COUNT_W    = 8;

  // Operation codes of an input beat.
  localparam logic OP_TICK     = 1'b0;
  localparam logic OP_RESPONSE = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_REQUEST = 2'd0;
  localparam logic [1:0] KIND_STORED  = 2'd1;
  localparam logic [1:0] KIND_UNKNOWN = 2'd2;

  // Table slots, in ascending PID order.
  localparam logic [SLOT_W-1:0] SLOT_LOAD     = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_COOLANT  = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_SPEED    = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_INTAKE   = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_THROTTLE = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_DISTANCE = 3'd5;
  localparam logic [SLOT_W-1:0] SLOT_VOLTAGE  = 3'd6;

  localparam logic [COUNT_W-1:0] COUNT_MAX       = 8'd255;
  localparam logic [COUNT_W-1:0] MISS_LIMIT_INIT = 8'd5;

  // Reciprocal multipliers, ceil(2^34 / d), for the two constant divisors.
  localparam int RECIP_SHIFT = 34;
  localparam int RECIP_W     = 27;
  localparam logic [RECIP_W-1:0] RECIP_255  = 27'd67372037;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 27'd17179870;

  // PID byte requested for each slot.
  function automatic logic [7:0] pid_of_slot(input logic [SLOT_W-1:0] s);
    logic [7:0] p;
    case (s)
      SLOT_LOAD:     p = 8'h04;
      SLOT_COOLANT:  p = 8'h05;
      SLOT_SPEED:    p = 8'h0D;
      SLOT_INTAKE:   p = 8'h0F;
      SLOT_THROTTLE: p = 8'h11;
      SLOT_DISTANCE: p = 8'h31;
      SLOT_VOLTAGE:  p = 8'h42;
      default:       p = 8'h04;
    endcase
    return p;
  endfunction

endpackage

/* rtl/core/obd2pp_in_if.sv */
// ----------------------------------------------------------------------------
// OBD-II poller input channel
// Valid/ready channel carrying poll ticks and received response frames.
// ----------------------------------------------------------------------------
interface obd2pp_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_pid;
  logic [7:0] rx_byte_a;
  logic [7:0] rx_byte_b;

  modport source (output valid, output operation, output rx_pid, output rx_byte_a,
                  output rx_byte_b, input ready);
  modport sink   (input valid, input operation, input rx_pid, input rx_byte_a,
                  input rx_byte_b, output ready);
endinterface

/* rtl/core/obd2pp_out_if.sv */
// ----------------------------------------------------------------------------
// OBD-II poller result channel
// Valid/ready channel carrying one result beat per input beat.
// ----------------------------------------------------------------------------
interface obd2pp_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [7:0]        request_pid;
  logic              timed_out;
  logic [2:0]        slot;
  logic signed [24:0] value_q8;
  logic              connected;

  modport source (output valid, output kind, output request_pid, output timed_out,
                  output slot, output value_q8, output connected, input ready);
  modport sink   (input valid, input kind, input request_pid, input timed_out,
                  input slot, input value_q8, input connected, output ready);
endinterface

/* rtl/core/obd2pp_decode.sv */
// ----------------------------------------------------------------------------
// OBD-II value decoder
// Turns bytes A and B of a response into a signed Q.8 value for its slot.
// ----------------------------------------------------------------------------
module obd2pp_decode import obd2pp_pkg::*; (
  input  logic [SLOT_W-1:0]         slot,
  input  logic [7:0]                byte_a,
  input  logic [7:0]                byte_b,
  output logic signed [VALUE_W-1:0] value
);

  localparam int PROD_W = VALUE_W + RECIP_W;

  logic               use_255;
  logic [VALUE_W-1:0] num_pct;
  logic [VALUE_W-1:0] num_volt;
  logic [VALUE_W-1:0] num;
  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  prod;
  logic [VALUE_W-1:0] quot;
  logic signed [9:0]  temp;

  // Percent scaling divides by 255, the module voltage by 1000; one shared
  // reciprocal multiplier serves both.
  assign use_255  = (slot == SLOT_LOAD) || (slot == SLOT_THROTTLE);
  assign num_pct  = VALUE_W'(byte_a) * VALUE_W'(25600) + VALUE_W'(127);
  assign num_volt = {1'b0, byte_a, byte_b, 8'h00} + VALUE_W'(500);
  assign num      = use_255 ? num_pct : num_volt;
  assign recip    = use_255 ? RECIP_255 : RECIP_1000;
  assign prod     = PROD_W'(num) * PROD_W'(recip);
  assign quot     = VALUE_W'(prod[PROD_W-1:RECIP_SHIFT]);

  // Temperatures are offset by 40 degrees and may go negative.
  assign temp = $signed({2'b00, byte_a}) - 10'sd40;

  // Select the decode that belongs to the slot.
  always_comb begin
    case (slot)
      SLOT_LOAD, SLOT_THROTTLE, SLOT_VOLTAGE: value = $signed(quot);
      SLOT_COOLANT, SLOT_INTAKE:              value = {{7{temp[9]}}, temp, 8'h00};
      SLOT_DISTANCE:                          value = {1'b0, byte_a, byte_b, 8'h00};
      default:                                value = {9'h000, byte_a, 8'h00};
    endcase
  end

endmodule

/* rtl/core/obd2_pid_poll_and_decode.sv */
// A result beat appears in the output register in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle while result.ready holds; the single
// output register is the only stage, and it refills in the same cycle its beat is taken.
// Reset (rst, synchronous, active high) clears the request pointer, all miss
// counters and the connected flag, empties the output register, and loads
// miss_limit with 5.
// ----------------------------------------------------------------------------
// OBD-II service 01 PID poller and decoder
// Issues round-robin PID requests, counts misses and decodes responses.
// ----------------------------------------------------------------------------
`include "obd2_pid_poll_and_decode_assert.svh"

module obd2_pid_poll_and_decode import obd2pp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  obd2pp_in_if.sink          item,
  obd2pp_out_if.source       result
);

  logic [COUNT_W-1:0] miss_limit;
  logic [SLOT_W-1:0]  next_slot;
  logic [COUNT_W-1:0] miss_count [SLOT_COUNT];
  logic               link_seen;

  logic                      res_valid;
  logic [1:0]                res_kind;
  logic [7:0]                res_pid;
  logic                      res_timed_out;
  logic [SLOT_W-1:0]         res_slot;
  logic signed [VALUE_W-1:0] res_value;
  logic                      res_connected;

  logic                      item_acc;
  logic                      is_resp;
  logic [SLOT_W-1:0]         tick_slot;
  logic [SLOT_W-1:0]         slot_next;
  logic [COUNT_W-1:0]        count_next;
  logic                      tick_timeout;
  logic                      hit;
  logic [SLOT_W-1:0]         hit_slot;
  logic signed [VALUE_W-1:0] dec_value;

  // Handshake: the output register frees up in the same cycle it is taken.
  assign item.ready = !res_valid || result.ready;
  assign item_acc   = item.valid && item.ready;
  assign is_resp    = (item.operation == OP_RESPONSE);

  // Poll tick: pick the slot, bump its saturating miss counter.
  assign tick_slot    = (next_slot < SLOT_W'(SLOT_COUNT)) ? next_slot : SLOT_LOAD;
  assign slot_next    = (tick_slot == SLOT_W'(SLOT_COUNT - 1)) ? SLOT_LOAD
                                                               : tick_slot + 1'b1;
  assign count_next   = (miss_count[tick_slot] == COUNT_MAX) ? COUNT_MAX
                                                             : miss_count[tick_slot] + 1'b1;
  assign tick_timeout = (count_next >= miss_limit);

  // Response: find the slot whose PID matches.
  always_comb begin
    hit      = 1'b0;
    hit_slot = SLOT_LOAD;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (pid_of_slot(SLOT_W'(i)) == item.rx_pid) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(i);
      end
    end
  end

  obd2pp_decode u_decode (
    .slot   (hit_slot),
    .byte_a (item.rx_byte_a),
    .byte_b (item.rx_byte_b),
    .value  (dec_value)
  );

  // Control state: configuration, pointer, counters, link flag, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      miss_limit <= MISS_LIMIT_INIT;
      next_slot  <= SLOT_LOAD;
      link_seen  <= 1'b0;
      res_valid  <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        miss_count[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        miss_limit <= cfg_wdata;
      end
      if (item_acc) begin
        res_valid <= 1'b1;
        if (!is_resp) begin
          miss_count[tick_slot] <= count_next;
          next_slot             <= slot_next;
        end else if (hit) begin
          miss_count[hit_slot] <= '0;
          link_seen            <= 1'b1;
        end
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted beat.
  always_ff @(posedge clk) begin
    if (item_acc) begin
      if (!is_resp) begin
        res_kind      <= KIND_REQUEST;
        res_pid       <= pid_of_slot(tick_slot);
        res_timed_out <= tick_timeout;
        res_slot      <= tick_slot;
        res_value     <= '0;
        res_connected <= link_seen;
      end else begin
        res_kind      <= hit ? KIND_STORED : KIND_UNKNOWN;
        res_pid       <= item.rx_pid;
        res_timed_out <= 1'b0;
        res_slot      <= hit ? hit_slot : SLOT_LOAD;
        res_value     <= hit ? dec_value : '0;
        res_connected <= link_seen || hit;
      end
    end
  end

  assign result.valid       = res_valid;
  assign result.kind        = res_kind;
  assign result.request_pid = res_pid;
  assign result.timed_out   = res_timed_out;
  assign result.slot        = res_slot;
  assign result.value_q8    = res_value;
  assign result.connected   = res_connected;

  // The request pointer never leaves the table.
  `OBD2PP_ASSERT_SAME(a_slot_range, clk, rst, 1'b1, next_slot < SLOT_W'(SLOT_COUNT),
                      "request pointer out of table range")
  // An accepted tick leaves a request beat waiting in the output register.
  `OBD2PP_ASSERT_NEXT(a_tick_result, clk, rst, item_acc && !is_resp,
                      result.valid && result.kind == KIND_REQUEST,
                      "poll tick did not produce a request beat")
  // A known response clears its counter and marks the link as up.
  `OBD2PP_ASSERT_NEXT(a_resp_clear, clk, rst, item_acc && is_resp && hit,
                      miss_count[$past(hit_slot)] == '0 && link_seen && result.connected,
                      "known response did not clear its miss counter")
  // A rejected PID reports slot zero and a zero value.
  `OBD2PP_ASSERT_SAME(a_unknown_zero, clk, rst, res_valid && res_kind == KIND_UNKNOWN,
                      res_slot == SLOT_LOAD && res_value == '0 && !res_timed_out,
                      "unknown PID beat carries a slot or value")

endmodule
